// ===== src/jcpa_pkg.sv =====
// Shared types and codes for the joint claim priority arbiter.
package jcpa_pkg;

  localparam int DEF_CLAIM_SLOTS   = 8;
  localparam int DEF_NUM_JOINTS    = 32;
  localparam int DEF_NUM_ENDPOINTS = 4;

  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_UPDATE   = 2'd1;
  localparam logic [1:0] OP_EVALUATE = 2'd2;
  localparam logic [1:0] OP_RELEASE  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_NOT_CONFIG = 3'd2;
  localparam logic [2:0] ST_REJECTED   = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  localparam logic [1:0] REC_STATUS    = 2'd0;
  localparam logic [1:0] REC_WINNER    = 2'd1;
  localparam logic [1:0] REC_PREEMPTED = 2'd2;
  localparam logic [1:0] REC_EXPIRED   = 2'd3;

  localparam logic [2:0] REG_ENABLED  = 3'd0;
  localparam logic [2:0] REG_IS_SERVO = 3'd1;
  localparam logic [2:0] REG_GROUP    = 3'd2;
  localparam logic [2:0] REG_PRIORITY = 3'd3;
  localparam logic [2:0] REG_LEASE    = 3'd4;

  typedef struct packed {
    logic [7:0]  session;
    logic [31:0] joints;
    logic        servo;
    logic [7:0]  prio;
    logic [31:0] sequence_no;
    logic [31:0] received;
    logic [15:0] lease;
  } slot_t;

endpackage

// ===== src/jcpa_ram.sv =====
// Generic single-port-write, registered-read RAM.
module jcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/joint_claim_priority_arbiter.sv =====
// Joint claim priority arbiter: claim table in RAM, walked by a sequencer.
// Sequence: one table scan, one decide step, then 0 to 3 winner selections, each
//   one table walk per eligible claim plus a last walk that finds none, then one
//   record per cycle while out_ready holds; an accepted move or servo update runs
//   three selections plus the control states and its records.
// Throughput: one request at a time; the next is taken once the last record
//   is loaded in the output register; requests are taken only in S_IDLE.
// Reset (rst_n, synchronous): clears slot valid bits, sequence counter, config
//   registers and control; RAM contents are left as they are (no clear pass).
module joint_claim_priority_arbiter #(
  parameter int CLAIM_SLOTS   = jcpa_pkg::DEF_CLAIM_SLOTS,
  parameter int NUM_JOINTS    = jcpa_pkg::DEF_NUM_JOINTS,
  parameter int NUM_ENDPOINTS = jcpa_pkg::DEF_NUM_ENDPOINTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_session_tag,
  input  logic [1:0]  in_endpoint_index,
  input  logic        in_claim_is_servo,
  input  logic [3:0]  in_claim_group,
  input  logic [31:0] in_joint_mask,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [2:0]  out_status,
  output logic        out_admitted,
  output logic [7:0]  out_session_out,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import jcpa_pkg::*;

  localparam int N  = CLAIM_SLOTS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int KW = $clog2(3 * N + 2);
  localparam logic [31:0] JOINT_LIMIT =
    (NUM_JOINTS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << NUM_JOINTS) - 64'd1);

  // sequencer states
  localparam logic [3:0] S_IDLE        = 4'd0;
  localparam logic [3:0] S_SCAN        = 4'd1;
  localparam logic [3:0] S_DECIDE      = 4'd2;
  localparam logic [3:0] S_PICK        = 4'd3;
  localparam logic [3:0] S_AFTER_OLD   = 4'd4;
  localparam logic [3:0] S_WRITE       = 4'd5;
  localparam logic [3:0] S_AFTER_CUR   = 4'd6;
  localparam logic [3:0] S_PREEMPT     = 4'd7;
  localparam logic [3:0] S_AFTER_FINAL = 4'd8;
  localparam logic [3:0] S_EMIT        = 4'd9;

  function automatic logic is_exp(slot_t d, logic [31:0] now);
    return d.servo && ((now - d.received) >= {16'd0, d.lease});
  endfunction

  // ---------------- config registers
  logic [3:0]  en_r, isv_r;
  logic [15:0] grpc_r;
  logic [31:0] pri_r;
  logic [63:0] lease_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= '0;
      isv_r   <= '0;
      grpc_r  <= '0;
      pri_r   <= '0;
      lease_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_ENABLED:  en_r    <= pwdata[3:0];
        REG_IS_SERVO: isv_r   <= pwdata[3:0];
        REG_GROUP:    grpc_r  <= pwdata[15:0];
        REG_PRIORITY: pri_r   <= pwdata[31:0];
        REG_LEASE:    lease_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_ENABLED:  prdata = {60'd0, en_r};
      REG_IS_SERVO: prdata = {60'd0, isv_r};
      REG_GROUP:    prdata = {48'd0, grpc_r};
      REG_PRIORITY: prdata = {32'd0, pri_r};
      REG_LEASE:    prdata = lease_r;
      default:      prdata = '0;
    endcase
  end

  // ---------------- claim table RAM
  slot_t          rd_slot, wr_slot;
  logic [AW-1:0]  raddr;
  logic           ram_we;
  logic [AW-1:0]  s_r, s_nxt;

  jcpa_ram #(.WIDTH($bits(slot_t)), .DEPTH(N)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_r),
    .wdata (wr_slot),
    .raddr (raddr),
    .rdata (rd_slot)
  );

  // ---------------- sequencer state
  logic [3:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0]    op_r;
  logic [7:0]    tag_r;
  logic [1:0]    ep_r;
  logic          csrv_r;
  logic [3:0]    grp_r;
  logic [31:0]   jm_r, now_r;
  logic [N-1:0]  valid_r, valid_nxt;
  logic [31:0]   seq_r, seq_nxt;

  // table walk: issue address, then evaluate the returned entry in the next cycle
  logic [AW:0]   wk_addr_r, wk_addr_nxt;
  logic          wk_vld_r, wk_vld_nxt;
  logic [AW-1:0] wk_idx_r, wk_idx_nxt;

  // scan results
  logic          hpre_r, hpre_nxt, hpost_r, hpost_nxt;
  logic [AW-1:0] ipre_r, ipre_nxt, ipost_r, ipost_nxt;
  logic [N-1:0]  xmask_r, xmask_nxt;
  logic [CW-1:0] xcnt_r, xcnt_nxt, xpos;
  logic [7:0]    xtag_r [N];
  logic [7:0]    xtag_nxt [N];

  // winner selection
  logic [N-1:0]  taken_r, taken_nxt;
  logic [31:0]   used_r, used_nxt;
  logic          bf_r, bf_nxt, bv_r, bv_nxt;
  logic [7:0]    bp_r, bp_nxt, bt_r, bt_nxt;
  logic [31:0]   bs_r, bs_nxt, bj_r, bj_nxt;
  logic [AW-1:0] bi_r, bi_nxt;
  logic [CW-1:0] wcnt_r, wcnt_nxt;
  logic [AW-1:0] widx_r [N];
  logic [AW-1:0] widx_nxt [N];
  logic [7:0]    wtag_r [N];
  logic [7:0]    wtag_nxt [N];
  logic [N-1:0]  wsrv_r, wsrv_nxt, wmask_r, wmask_nxt;

  // winners before the new claim went in
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic [AW-1:0] oidx_r [N];
  logic [AW-1:0] oidx_nxt [N];
  logic [7:0]    otag_r [N];
  logic [7:0]    otag_nxt [N];
  logic [N-1:0]  osrv_r, osrv_nxt;

  // preempted list
  logic [CW-1:0] pcnt_r, pcnt_nxt, pw_r, pw_nxt;
  logic [7:0]    ptag_r [N];
  logic [7:0]    ptag_nxt [N];

  logic [2:0]    st_r, st_nxt, vst;
  logic          adm_r, adm_nxt;
  logic [KW-1:0] em_r, em_nxt, em_total, em_off;

  logic          ov_r, ov_nxt, olast_r, olast_nxt, oadm_r, oadm_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [7:0]    osess_r, osess_nxt;

  logic          pick_go, free_found, elig, better, accept_in, walk_done;
  logic [3:0]    pick_ret;
  logic [AW-1:0] free_idx, oi;

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid & in_ready;
  assign raddr     = wk_addr_r[AW-1:0];
  assign walk_done = (wk_addr_r == (AW+1)'(N)) && !wk_vld_r;
  assign ram_we    = (state_r == S_WRITE);

  always_comb begin
    wr_slot.session     = tag_r;
    wr_slot.joints      = jm_r;
    wr_slot.servo       = (op_r == OP_UPDATE);
    wr_slot.prio        = pri_r[ep_r*8 +: 8];
    wr_slot.sequence_no = seq_r;
    wr_slot.received    = now_r;
    wr_slot.lease       = lease_r[ep_r*16 +: 16];
  end

  // first free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    wk_addr_nxt = wk_addr_r;
    wk_vld_nxt  = wk_vld_r;
    wk_idx_nxt  = wk_idx_r;
    hpre_nxt  = hpre_r;
    hpost_nxt = hpost_r;
    ipre_nxt  = ipre_r;
    ipost_nxt = ipost_r;
    xmask_nxt = xmask_r;
    xcnt_nxt  = xcnt_r;
    xtag_nxt  = xtag_r;
    taken_nxt = taken_r;
    used_nxt  = used_r;
    bf_nxt = bf_r; bv_nxt = bv_r; bp_nxt = bp_r; bt_nxt = bt_r;
    bs_nxt = bs_r; bj_nxt = bj_r; bi_nxt = bi_r;
    wcnt_nxt  = wcnt_r;
    widx_nxt  = widx_r;
    wtag_nxt  = wtag_r;
    wsrv_nxt  = wsrv_r;
    wmask_nxt = wmask_r;
    ocnt_nxt  = ocnt_r;
    oidx_nxt  = oidx_r;
    otag_nxt  = otag_r;
    osrv_nxt  = osrv_r;
    pcnt_nxt  = pcnt_r;
    pw_nxt    = pw_r;
    ptag_nxt  = ptag_r;
    s_nxt     = s_r;
    st_nxt    = st_r;
    adm_nxt   = adm_r;
    em_nxt    = em_r;
    ov_nxt    = ov_r;
    olast_nxt = olast_r;
    oadm_nxt  = oadm_r;
    okind_nxt = okind_r;
    ost_nxt   = ost_r;
    osess_nxt = osess_r;
    pick_go   = 1'b0;
    pick_ret  = S_EMIT;
    vst       = ST_OK;
    xpos      = '0;
    elig      = 1'b0;
    better    = 1'b0;
    oi        = '0;
    em_total  = KW'(1) + KW'(wcnt_r) + KW'(pcnt_r) + KW'(xcnt_r);
    em_off    = '0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    // shared address walk for scan and selection
    if (state_r == S_SCAN || state_r == S_PICK) begin
      if (wk_addr_r < (AW+1)'(N)) begin
        wk_addr_nxt = wk_addr_r + 1'b1;
        wk_vld_nxt  = 1'b1;
        wk_idx_nxt  = wk_addr_r[AW-1:0];
      end else begin
        wk_vld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          state_nxt   = S_SCAN;
          wk_addr_nxt = '0;
          wk_vld_nxt  = 1'b0;
          hpre_nxt    = 1'b0;
          hpost_nxt   = 1'b0;
          xmask_nxt   = '0;
          xcnt_nxt    = '0;
          pcnt_nxt    = '0;
        end
      end

      S_SCAN: begin
        if (wk_vld_r && valid_r[wk_idx_r]) begin
          if (rd_slot.session == tag_r) begin
            if (!hpre_r) begin
              hpre_nxt = 1'b1;
              ipre_nxt = wk_idx_r;
            end
            if (!hpost_r && !is_exp(rd_slot, now_r)) begin
              hpost_nxt = 1'b1;
              ipost_nxt = wk_idx_r;
            end
          end
          if (is_exp(rd_slot, now_r)) begin
            // sorted insert, equal tags keep arrival order
            xmask_nxt[wk_idx_r] = 1'b1;
            xcnt_nxt = xcnt_r + 1'b1;
            for (int j = 0; j < N; j++) begin
              if (CW'(j) < xcnt_r && xtag_r[j] <= rd_slot.session) begin
                xpos = xpos + 1'b1;
              end
            end
            for (int j = 0; j < N; j++) begin
              if (CW'(j) == xpos) begin
                xtag_nxt[j] = rd_slot.session;
              end else if (CW'(j) > xpos && j > 0) begin
                xtag_nxt[j] = xtag_r[j-1];
              end
            end
          end
        end
        if (walk_done) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        adm_nxt = 1'b0;
        em_nxt  = '0;
        if (op_r == OP_RELEASE) begin
          if (hpre_r) begin
            valid_nxt[ipre_r] = 1'b0;
          end
          st_nxt    = ST_OK;
          wcnt_nxt  = '0;
          xcnt_nxt  = '0;
          state_nxt = S_EMIT;
        end else if (op_r == OP_EVALUATE) begin
          valid_nxt = valid_r & ~xmask_r;
          st_nxt    = ST_OK;
          pick_go   = 1'b1;
          pick_ret  = S_EMIT;
        end else begin
          if (jm_r == '0) begin
            vst = ST_INVALID;
          end else if ({1'b0, ep_r} >= 3'(NUM_ENDPOINTS) || !en_r[ep_r]) begin
            vst = ST_NOT_CONFIG;
          end else if (isv_r[ep_r] != csrv_r || grpc_r[ep_r*4 +: 4] != grp_r) begin
            vst = ST_INVALID;
          end else if (csrv_r != (op_r == OP_UPDATE)) begin
            vst = ST_INVALID;
          end else if (op_r == OP_SUBMIT && hpre_r) begin
            vst = ST_INVALID;
          end
          st_nxt  = vst;
          pick_go = 1'b1;
          if (vst != ST_OK) begin
            xcnt_nxt = '0;
            pick_ret = S_EMIT;
          end else begin
            valid_nxt = valid_r & ~xmask_r;
            pick_ret  = S_AFTER_OLD;
          end
        end
      end

      S_PICK: begin
        if (wk_vld_r) begin
          elig = valid_r[wk_idx_r] && !taken_r[wk_idx_r] && !is_exp(rd_slot, now_r);
          better = !bf_r || (rd_slot.prio > bp_r) ||
                   (rd_slot.prio == bp_r && rd_slot.sequence_no > bs_r);
          if (elig && better) begin
            bf_nxt = 1'b1;
            bp_nxt = rd_slot.prio;
            bs_nxt = rd_slot.sequence_no;
            bi_nxt = wk_idx_r;
            bj_nxt = rd_slot.joints;
            bt_nxt = rd_slot.session;
            bv_nxt = rd_slot.servo;
          end
        end
        if (walk_done) begin
          if (bf_r) begin
            taken_nxt[bi_r] = 1'b1;
            if ((used_r & bj_r) == '0) begin
              used_nxt = used_r | bj_r;
              widx_nxt[wcnt_r[AW-1:0]] = bi_r;
              wtag_nxt[wcnt_r[AW-1:0]] = bt_r;
              wsrv_nxt[wcnt_r[AW-1:0]] = bv_r;
              wmask_nxt[bi_r] = 1'b1;
              wcnt_nxt = wcnt_r + 1'b1;
            end
            wk_addr_nxt = '0;
            bf_nxt      = 1'b0;
          end else begin
            state_nxt = ret_r;
          end
        end
      end

      S_AFTER_OLD: begin
        ocnt_nxt = wcnt_r;
        oidx_nxt = widx_r;
        otag_nxt = wtag_r;
        osrv_nxt = wsrv_r;
        if (op_r == OP_UPDATE && hpost_r) begin
          s_nxt     = ipost_r;
          state_nxt = S_WRITE;
        end else if (free_found) begin
          s_nxt     = free_idx;
          state_nxt = S_WRITE;
        end else begin
          st_nxt    = ST_TABLE_FULL;
          state_nxt = S_EMIT;
        end
      end

      S_WRITE: begin
        valid_nxt[s_r] = 1'b1;
        seq_nxt  = seq_r + 32'd1;
        pick_go  = 1'b1;
        pick_ret = S_AFTER_CUR;
      end

      S_AFTER_CUR: begin
        pw_nxt    = '0;
        pcnt_nxt  = '0;
        state_nxt = S_PREEMPT;
      end

      S_PREEMPT: begin
        // old winners that lost, in old winner order; servos stay
        if (pw_r < ocnt_r) begin
          oi = oidx_r[pw_r[AW-1:0]];
          if (!wmask_r[oi] && oi != s_r && !osrv_r[pw_r[AW-1:0]]) begin
            ptag_nxt[pcnt_r[AW-1:0]] = otag_r[pw_r[AW-1:0]];
            pcnt_nxt = pcnt_r + 1'b1;
            valid_nxt[oi] = 1'b0;
          end
          pw_nxt = pw_r + 1'b1;
        end else begin
          pick_go  = 1'b1;
          pick_ret = S_AFTER_FINAL;
        end
      end

      S_AFTER_FINAL: begin
        if (wmask_r[s_r]) begin
          st_nxt  = ST_OK;
          adm_nxt = 1'b1;
        end else if (op_r == OP_UPDATE) begin
          st_nxt = ST_OK;
        end else begin
          // a losing new move never won, so the winner list stands
          valid_nxt[s_r] = 1'b0;
          st_nxt = ST_REJECTED;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          olast_nxt = (em_r == em_total - 1'b1);
          oadm_nxt  = 1'b0;
          ost_nxt   = ST_OK;
          osess_nxt = '0;
          if (em_r == '0) begin
            okind_nxt = REC_STATUS;
            ost_nxt   = st_r;
            oadm_nxt  = adm_r;
          end else if (em_r <= KW'(wcnt_r)) begin
            em_off    = em_r - 1'b1;
            okind_nxt = REC_WINNER;
            osess_nxt = wtag_r[em_off[AW-1:0]];
          end else if (em_r <= KW'(wcnt_r) + KW'(pcnt_r)) begin
            em_off    = em_r - 1'b1 - KW'(wcnt_r);
            okind_nxt = REC_PREEMPTED;
            osess_nxt = ptag_r[em_off[AW-1:0]];
          end else begin
            em_off    = em_r - 1'b1 - KW'(wcnt_r) - KW'(pcnt_r);
            okind_nxt = REC_EXPIRED;
            osess_nxt = xtag_r[em_off[AW-1:0]];
          end
          em_nxt = em_r + 1'b1;
          if (em_r == em_total - 1'b1) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (pick_go) begin
      state_nxt   = S_PICK;
      ret_nxt     = pick_ret;
      taken_nxt   = '0;
      used_nxt    = '0;
      wcnt_nxt    = '0;
      wmask_nxt   = '0;
      wk_addr_nxt = '0;
      wk_vld_nxt  = 1'b0;
      bf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_EMIT;
      valid_r  <= '0;
      seq_r    <= '0;
      wk_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      valid_r  <= valid_nxt;
      seq_r    <= seq_nxt;
      wk_vld_r <= wk_vld_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_r   <= in_operation;
      tag_r  <= in_session_tag;
      ep_r   <= in_endpoint_index;
      csrv_r <= in_claim_is_servo;
      grp_r  <= in_claim_group;
      jm_r   <= in_joint_mask & JOINT_LIMIT;
      now_r  <= in_now_ms;
    end
    wk_addr_r <= wk_addr_nxt;
    wk_idx_r  <= wk_idx_nxt;
    hpre_r    <= hpre_nxt;
    hpost_r   <= hpost_nxt;
    ipre_r    <= ipre_nxt;
    ipost_r   <= ipost_nxt;
    xmask_r   <= xmask_nxt;
    xcnt_r    <= xcnt_nxt;
    xtag_r    <= xtag_nxt;
    taken_r   <= taken_nxt;
    used_r    <= used_nxt;
    bf_r <= bf_nxt; bv_r <= bv_nxt; bp_r <= bp_nxt; bt_r <= bt_nxt;
    bs_r <= bs_nxt; bj_r <= bj_nxt; bi_r <= bi_nxt;
    wcnt_r    <= wcnt_nxt;
    widx_r    <= widx_nxt;
    wtag_r    <= wtag_nxt;
    wsrv_r    <= wsrv_nxt;
    wmask_r   <= wmask_nxt;
    ocnt_r    <= ocnt_nxt;
    oidx_r    <= oidx_nxt;
    otag_r    <= otag_nxt;
    osrv_r    <= osrv_nxt;
    pcnt_r    <= pcnt_nxt;
    pw_r      <= pw_nxt;
    ptag_r    <= ptag_nxt;
    s_r       <= s_nxt;
    st_r      <= st_nxt;
    adm_r     <= adm_nxt;
    em_r      <= em_nxt;
    olast_r   <= olast_nxt;
    oadm_r    <= oadm_nxt;
    okind_r   <= okind_nxt;
    ost_r     <= ost_nxt;
    osess_r   <= osess_nxt;
  end

  assign out_valid       = ov_r;
  assign out_record_kind = okind_r;
  assign out_status      = ost_r;
  assign out_admitted    = oadm_r;
  assign out_session_out = osess_r;
  assign out_last        = olast_r;

endmodule
